// File: rtl/pual_pkg.sv
// Package for the primary user activity lookup block.
// Item and result structs, table word types, mode and register codes, FSM states.
// No dependencies.
package pual_pkg;

    localparam int DEF_MAX_ENTRIES   = 16;
    localparam int DEF_MAX_INTERVALS = 64;

    localparam logic [47:0] OFF_WINDOW_NS = 48'd1000000;
    localparam logic [31:0] NS_PER_SEC    = 32'd1000000000;
    localparam logic [23:0] GAIN_RESET    = 24'd93494;

    localparam logic [2:0] MODE_LOAD_ENTRY = 3'd0;
    localparam logic [2:0] MODE_LOAD_IVL   = 3'd1;
    localparam logic [2:0] MODE_LOCAL      = 3'd2;
    localparam logic [2:0] MODE_ANY        = 3'd3;
    localparam logic [2:0] MODE_NEXT_OFF   = 3'd4;
    localparam logic [2:0] MODE_INTERF     = 3'd5;

    localparam logic REG_PU_COUNT = 1'b0;
    localparam logic REG_GAIN     = 1'b1;

    localparam int MUL_A_W   = 96;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = 128;
    localparam int MUL_LIMBS = MUL_A_W / MUL_B_W;

    localparam int DIV_HI_W  = 40;
    localparam int DIV_LO_W  = 64;
    localparam int DIV_DEN_W = 116;

    typedef struct packed {
        logic [2:0]         mode;
        logic [3:0]         pu_index;
        logic [5:0]         slot_index;
        logic [7:0]         channel;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] rx_x;
        logic signed [19:0] rx_y;
        logic [19:0]        radius;
        logic [6:0]         interval_count;
        logic [47:0]        time_a;
        logic [47:0]        time_b;
    } t_in_item;

    typedef struct packed {
        logic        active;
        logic [47:0] off_time;
        logic [63:0] power_total;
        logic [31:0] event_count;
    } t_out_item;

    typedef struct packed {
        logic [7:0]         channel;
        logic signed [19:0] tx_x;
        logic signed [19:0] tx_y;
        logic signed [19:0] rx_x;
        logic signed [19:0] rx_y;
        logic [19:0]        radius;
        logic [6:0]         count;
    } t_entry;

    typedef struct packed {
        logic        flag;
        logic [47:0] dep;
        logic [47:0] arr;
    } t_ivl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENT_RD,
        ST_DX,
        ST_DY,
        ST_RR,
        ST_CHK,
        ST_IV_RD,
        ST_IV_CHK,
        ST_M_GAIN,
        ST_M_SLO,
        ST_M_SHI,
        ST_M_DEN,
        ST_DIV,
        ST_ACC,
        ST_NEXT
    } t_state;

endpackage

// File: rtl/primary_user_activity_lookup_top.sv
// Top level of the primary user activity lookup block: sequencer, config port.
// Depends on pual_pkg, pual_store, pual_mul, pual_div.
//
// Usage: raise start with an item on i_item while busy is low; the item is
// taken at that edge. Exactly one result per item appears on o_result for one
// cycle, marked by o_valid. The receiver cannot stall; results are never held.
// Load items and unused modes finish in idle; the result follows on the next cycle.
// Queries walk the entries in order, one entry and one interval per memory
// read: each entry is read, then, when a channel and distance test applies,
// squared in the dx, dy and radius steps, then checked; its intervals are then
// read and checked one by one. A query ends at the first hit, except interference,
// which scans all entries; each interference hit at nonzero distance runs four
// passes of the limb multiplier, a divider pass and the accumulate step; at
// zero distance it goes straight to the accumulate step.
// Config via APB: pu_count at 0x0, interference_gain at 0x4; write only idle.
// Reset: accumulators zero, pu_count 0, gain 93494; tables are undefined until
// loaded, no clearing pass.
module primary_user_activity_lookup_top #(
    parameter int MAX_ENTRIES   = pual_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_INTERVALS = pual_pkg::DEF_MAX_INTERVALS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  pual_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_valid,
    output pual_pkg::t_out_item o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pual_pkg::*;

    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int AW = (MAX_ENTRIES * MAX_INTERVALS > 1) ?
                        $clog2(MAX_ENTRIES * MAX_INTERVALS) : 1;
    localparam int NW = $clog2(MAX_ENTRIES + 1);

    t_state      r_state, n_state;
    logic        r_wait;
    logic        r_valid;
    t_out_item   r_res;
    logic [4:0]  r_pu_count;
    logic [23:0] r_gain;
    logic [63:0] r_power;
    logic [31:0] r_event;

    logic [2:0]         r_mode;
    logic [7:0]         r_chan;
    logic signed [19:0] r_px, r_py;
    logic [47:0]        r_ta, r_tb;
    logic [48:0]        r_end;
    logic [EW-1:0]      r_e;
    logic [6:0]         r_i;
    logic [42:0]        r_sq, r_s, r_rr;
    logic [71:0]        r_num;
    logic [74:0]        r_t;
    logic [85:0]        r_s2;
    logic [DIV_DEN_W-1:0] r_den;
    logic [63:0]        r_inc;
    logic               r_active;

    logic          w_accept, w_cfg_wr, w_pidx_ok, w_slot_ok, w_ovl, w_ent_ok, w_last;
    logic [NW-1:0] w_n;
    t_entry        w_ent, w_ent_wdata;
    t_ivl          w_ivl, w_ivl_wdata;
    logic [AW-1:0] w_scan_addr, w_load_addr, w_ivl_waddr;
    logic          w_ent_we, w_ivl_we;
    logic signed [19:0] w_ex, w_ey;
    logic signed [20:0] w_dx, w_dy;
    logic [20:0]   w_sq_op;
    logic [41:0]   w_sq;
    logic [48:0]   w_arr, w_dep, w_now;
    logic          w_emit, w_emit_active;
    logic [47:0]   w_emit_off;
    logic          w_mul_start, w_mul_done, w_div_start, w_div_done;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_P_W-1:0] w_mul_p;
    logic [63:0]   w_div_q;
    logic [64:0]   w_psum;

    assign w_accept  = start && !busy;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_GAIN) ? 32'(r_gain) : 32'(r_pu_count);
    assign busy      = (r_state != ST_IDLE);
    assign o_valid   = r_valid;
    assign o_result  = r_res;

    assign w_n = (32'(r_pu_count) > MAX_ENTRIES) ? NW'(MAX_ENTRIES) : NW'(r_pu_count);
    assign w_pidx_ok = 32'(i_item.pu_index) < MAX_ENTRIES;
    assign w_slot_ok = 32'(i_item.slot_index) < MAX_INTERVALS;
    assign w_last    = (NW'(r_e) + NW'(1)) == w_n;

    assign w_scan_addr = AW'(32'(r_e) * MAX_INTERVALS + 32'(r_i));
    assign w_load_addr = AW'(32'(i_item.pu_index) * MAX_INTERVALS + 32'(i_item.slot_index));

    always_comb begin
        w_ent_wdata.channel = i_item.channel;
        w_ent_wdata.tx_x    = i_item.pos_x;
        w_ent_wdata.tx_y    = i_item.pos_y;
        w_ent_wdata.rx_x    = i_item.rx_x;
        w_ent_wdata.rx_y    = i_item.rx_y;
        w_ent_wdata.radius  = i_item.radius;
        w_ent_wdata.count   = (32'(i_item.interval_count) > MAX_INTERVALS) ?
                              7'(MAX_INTERVALS) : i_item.interval_count;
    end

    pual_store #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .MAX_INTERVALS(MAX_INTERVALS)
    ) u_store (
        .i_clk       (i_clk),
        .i_ent_we    (w_ent_we),
        .i_ent_waddr (EW'(i_item.pu_index)),
        .i_ent_wdata (w_ent_wdata),
        .i_ent_raddr (r_e),
        .o_ent_rdata (w_ent),
        .i_ivl_we    (w_ivl_we),
        .i_ivl_waddr (w_ivl_waddr),
        .i_ivl_wdata (w_ivl_wdata),
        .i_ivl_raddr (w_scan_addr),
        .o_ivl_rdata (w_ivl)
    );

    pual_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_mul_start),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_mul_p),
        .o_done (w_mul_done)
    );

    pual_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num_hi(r_num[71:32]),
        .i_num_lo({r_num[31:0], 32'd0}),
        .i_den   (r_den),
        .o_q     (w_div_q),
        .o_done  (w_div_done)
    );

    // distance to tx for local queries, to rx for interference
    assign w_ex = (r_mode == MODE_INTERF) ? w_ent.rx_x : w_ent.tx_x;
    assign w_ey = (r_mode == MODE_INTERF) ? w_ent.rx_y : w_ent.tx_y;
    assign w_dx = 21'(r_px) - 21'(w_ex);
    assign w_dy = 21'(r_py) - 21'(w_ey);
    assign w_sq = w_sq_op * w_sq_op;

    assign w_arr = 49'(w_ivl.arr);
    assign w_dep = 49'(w_ivl.dep);
    assign w_now = 49'(r_ta);
    assign w_ovl = (w_arr >= w_now && w_dep >= r_end && w_arr <= r_end) ||
                   (w_arr <= w_now && w_dep >= r_end) ||
                   (w_arr <= w_now && w_dep >= w_now && w_dep <= r_end);

    always_comb begin
        priority if (r_mode == MODE_ANY || r_mode == MODE_NEXT_OFF) begin
            w_ent_ok = 1'b1;
        end else if (r_mode == MODE_LOCAL) begin
            w_ent_ok = (w_ent.channel == r_chan) && (r_s <= r_rr);
        end else begin
            w_ent_ok = (w_ent.channel == r_chan) && (r_s < r_rr);
        end
    end

    assign w_psum = 65'(r_power) + 65'(r_inc);

    always_comb begin
        n_state       = r_state;
        w_emit        = 1'b0;
        w_emit_active = r_active;
        w_emit_off    = '0;
        w_mul_start   = 1'b0;
        w_div_start   = 1'b0;
        w_mul_a       = '0;
        w_mul_b       = '0;
        w_sq_op       = '0;
        w_ent_we      = 1'b0;
        w_ivl_we      = 1'b0;
        w_ivl_waddr   = w_scan_addr;
        w_ivl_wdata   = '{flag: 1'b1, dep: w_ivl.dep, arr: w_ivl.arr};
        unique case (r_state)
            ST_IDLE: begin
                w_emit_active = 1'b0;
                if (w_accept) begin
                    case (i_item.mode)
                        MODE_LOAD_ENTRY: begin
                            w_ent_we = w_pidx_ok;
                            w_emit   = 1'b1;
                        end
                        MODE_LOAD_IVL: begin
                            w_ivl_we    = w_pidx_ok && w_slot_ok;
                            w_ivl_waddr = w_load_addr;
                            w_ivl_wdata = '{flag: 1'b0, dep: i_item.time_b,
                                            arr: i_item.time_a};
                            w_emit      = 1'b1;
                        end
                        MODE_LOCAL, MODE_ANY, MODE_NEXT_OFF, MODE_INTERF: begin
                            if (w_n == '0) begin
                                w_emit = 1'b1;
                            end else begin
                                n_state = ST_ENT_RD;
                            end
                        end
                        default: w_emit = 1'b1;
                    endcase
                end
            end
            ST_ENT_RD: begin
                n_state = (r_mode == MODE_ANY || r_mode == MODE_NEXT_OFF) ? ST_CHK : ST_DX;
            end
            ST_DX: begin
                w_sq_op = w_dx[20] ? 21'(-w_dx) : 21'(w_dx);
                n_state = ST_DY;
            end
            ST_DY: begin
                w_sq_op = w_dy[20] ? 21'(-w_dy) : 21'(w_dy);
                n_state = ST_RR;
            end
            ST_RR: begin
                w_sq_op = 21'(w_ent.radius);
                n_state = ST_CHK;
            end
            ST_CHK: begin
                n_state = (w_ent_ok && w_ent.count != '0) ? ST_IV_RD : ST_NEXT;
            end
            ST_IV_RD: n_state = ST_IV_CHK;
            ST_IV_CHK: begin
                if (w_ovl) begin
                    w_ivl_we = 1'b1;
                    if (r_mode == MODE_INTERF) begin
                        n_state = (r_s == '0) ? ST_ACC : ST_M_GAIN;
                    end else begin
                        w_emit        = 1'b1;
                        w_emit_active = 1'b1;
                        w_emit_off    = w_ivl.dep;
                        n_state       = ST_IDLE;
                    end
                end else if (w_arr > r_end || (r_i + 7'd1) == w_ent.count) begin
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_IV_RD;
                end
            end
            ST_M_GAIN: begin
                w_mul_a     = MUL_A_W'(r_tb);
                w_mul_b     = MUL_B_W'(r_gain);
                w_mul_start = !r_wait;
                if (r_wait && w_mul_done) n_state = ST_M_SLO;
            end
            ST_M_SLO: begin
                w_mul_a     = MUL_A_W'(r_s);
                w_mul_b     = r_s[31:0];
                w_mul_start = !r_wait;
                if (r_wait && w_mul_done) n_state = ST_M_SHI;
            end
            ST_M_SHI: begin
                w_mul_a     = MUL_A_W'(r_s);
                w_mul_b     = MUL_B_W'(r_s[42:32]);
                w_mul_start = !r_wait;
                if (r_wait && w_mul_done) n_state = ST_M_DEN;
            end
            ST_M_DEN: begin
                w_mul_a     = MUL_A_W'(r_s2);
                w_mul_b     = NS_PER_SEC;
                w_mul_start = !r_wait;
                if (r_wait && w_mul_done) n_state = ST_DIV;
            end
            ST_DIV: begin
                w_div_start = !r_wait;
                if (r_wait && w_div_done) n_state = ST_ACC;
            end
            ST_ACC: n_state = ST_NEXT;
            ST_NEXT: begin
                if (w_last) begin
                    w_emit  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_ENT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wait     <= 1'b0;
            r_valid    <= 1'b0;
            r_pu_count <= '0;
            r_gain     <= GAIN_RESET;
            r_power    <= '0;
            r_event    <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= w_emit;
            if (w_mul_start || w_div_start) begin
                r_wait <= 1'b1;
            end else if (w_mul_done || w_div_done) begin
                r_wait <= 1'b0;
            end
            if (w_cfg_wr) begin
                if (paddr[2] == REG_GAIN) begin
                    r_gain <= pwdata[23:0];
                end else begin
                    r_pu_count <= pwdata[4:0];
                end
            end
            if (r_state == ST_ACC) begin
                r_power <= w_psum[64] ? '1 : w_psum[63:0];
                if (r_event != '1) r_event <= r_event + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_res <= '{active: w_emit_active, off_time: w_emit_off,
                       power_total: r_power, event_count: r_event};
        end
        unique case (r_state)
            ST_IDLE: begin
                r_mode   <= i_item.mode;
                r_chan   <= i_item.channel;
                r_px     <= i_item.pos_x;
                r_py     <= i_item.pos_y;
                r_ta     <= i_item.time_a;
                r_tb     <= i_item.time_b;
                r_end    <= 49'(i_item.time_a) + ((i_item.mode == MODE_NEXT_OFF) ?
                            49'(OFF_WINDOW_NS) : 49'(i_item.time_b));
                r_e      <= '0;
                r_active <= 1'b0;
            end
            ST_DX: r_sq <= 43'(w_sq);
            ST_DY: r_s  <= r_sq + 43'(w_sq);
            ST_RR: r_rr <= 43'(w_sq);
            ST_CHK: r_i <= '0;
            ST_IV_CHK: begin
                r_i <= r_i + 7'd1;
                if (w_ovl) begin
                    r_active <= 1'b1;
                    r_inc    <= '1;
                end
            end
            ST_M_GAIN: if (r_wait && w_mul_done) r_num <= w_mul_p[71:0];
            ST_M_SLO:  if (r_wait && w_mul_done) r_t <= w_mul_p[74:0];
            ST_M_SHI: begin
                if (r_wait && w_mul_done) begin
                    r_s2 <= 86'(r_t) + {w_mul_p[53:0], 32'd0};
                end
            end
            ST_M_DEN:  if (r_wait && w_mul_done) r_den <= w_mul_p[DIV_DEN_W-1:0];
            ST_DIV:    if (r_wait && w_div_done) r_inc <= w_div_q;
            ST_NEXT:   r_e <= r_e + EW'(1);
            default: ;
        endcase
    end

    a_load_responds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.mode == MODE_LOAD_ENTRY) |=> o_valid)
        else $error("entry load gave no result");

    a_busy_falls_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_valid)
        else $error("query ended without a result");

    a_events_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_event >= $past(r_event)))
        else $error("event count went down");

endmodule

// File: rtl/pual_mul.sv
// Multi-cycle 96x32 unsigned multiplier, one 32x32 limb product per cycle.
// Depends on pual_pkg.
module pual_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pual_pkg::MUL_A_W-1:0] i_a,
    input  logic [pual_pkg::MUL_B_W-1:0] i_b,
    output logic [pual_pkg::MUL_P_W-1:0] o_prod,
    output logic                        o_done
);
    import pual_pkg::*;

    localparam int KW = (MUL_LIMBS > 1) ? $clog2(MUL_LIMBS) : 1;

    logic                 r_busy;
    logic                 r_done;
    logic [KW-1:0]        r_k;
    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_B_W-1:0]   r_b;
    logic [MUL_P_W-1:0]   r_acc;
    logic [2*MUL_B_W-1:0] w_pp;

    assign w_pp = r_a[MUL_A_W-1 -: MUL_B_W] * r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= KW'(MUL_LIMBS - 1);
            end else if (r_busy) begin
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - KW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc << MUL_B_W) + MUL_P_W'(w_pp);
            r_a   <= r_a << MUL_B_W;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

// File: rtl/pual_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit quotient saturating.
// Depends on pual_pkg.
module pual_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pual_pkg::DIV_HI_W-1:0]  i_num_hi,
    input  logic [pual_pkg::DIV_LO_W-1:0]  i_num_lo,
    input  logic [pual_pkg::DIV_DEN_W-1:0] i_den,
    output logic [pual_pkg::DIV_LO_W-1:0]  o_q,
    output logic                          o_done
);
    import pual_pkg::*;

    localparam int CW = $clog2(DIV_LO_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [DIV_DEN_W:0]   r_rem;
    logic [DIV_LO_W-1:0]  r_num;
    logic [DIV_LO_W-1:0]  r_q;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   w_t;
    logic                 w_ge;
    logic                 w_sat;

    assign w_sat = DIV_DEN_W'(i_num_hi) >= i_den;
    assign w_t   = {r_rem[DIV_DEN_W-1:0], r_num[DIV_LO_W-1]};
    assign w_ge  = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !w_sat;
                r_done <= w_sat;
                r_cnt  <= CW'(DIV_LO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (DIV_DEN_W + 1)'(i_num_hi);
            r_num <= i_num_lo;
            r_den <= i_den;
            r_q   <= w_sat ? '1 : '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_t - {1'b0, r_den}) : w_t;
            r_num <= r_num << 1;
            r_q   <= {r_q[DIV_LO_W-2:0], w_ge};
        end
    end

    assign o_q    = r_q;
    assign o_done = r_done;

endmodule

// File: rtl/pual_store.sv
// Entry table and interval table, synchronous memories with registered read.
// Depends on pual_pkg.
module pual_store #(
    parameter int  MAX_ENTRIES   = pual_pkg::DEF_MAX_ENTRIES,
    parameter int  MAX_INTERVALS = pual_pkg::DEF_MAX_INTERVALS,
    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int AW = (MAX_ENTRIES * MAX_INTERVALS > 1) ?
                        $clog2(MAX_ENTRIES * MAX_INTERVALS) : 1
) (
    input  logic             i_clk,
    input  logic             i_ent_we,
    input  logic [EW-1:0]    i_ent_waddr,
    input  pual_pkg::t_entry i_ent_wdata,
    input  logic [EW-1:0]    i_ent_raddr,
    output pual_pkg::t_entry o_ent_rdata,
    input  logic             i_ivl_we,
    input  logic [AW-1:0]    i_ivl_waddr,
    input  pual_pkg::t_ivl   i_ivl_wdata,
    input  logic [AW-1:0]    i_ivl_raddr,
    output pual_pkg::t_ivl   o_ivl_rdata
);
    import pual_pkg::*;

    t_entry r_ent_mem [MAX_ENTRIES];
    t_ivl   r_ivl_mem [MAX_ENTRIES * MAX_INTERVALS];

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            r_ent_mem[i_ent_waddr] <= i_ent_wdata;
        end
        o_ent_rdata <= r_ent_mem[i_ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ivl_we) begin
            r_ivl_mem[i_ivl_waddr] <= i_ivl_wdata;
        end
        o_ivl_rdata <= r_ivl_mem[i_ivl_raddr];
    end

endmodule
